>>> hdl/osq_pkg.sv
// shared types, constants and the ranking function for the ordered score queue
// no dependencies; imported by every module of the block
package osq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int SCORE_W  = 32;
  localparam int TOTAL_W  = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]                operation;
    logic [ID_W-1:0]           item_id;
    logic signed [SCORE_W-1:0] item_score;
  } req_word_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [ID_W-1:0]           head_id;
    logic signed [SCORE_W-1:0] head_score;
    logic                      empty_res;
    logic [TOTAL_W-1:0]        entry_total;
  } rsp_word_t;

  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           ident;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SHIFT  = 2'd3
  } cell_cmd_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_cmd_t                 cmd;
    logic signed [SCORE_W-1:0] key_score;
    logic [ID_W-1:0]           key_ident;
  } chain_ctl_t;

  // true when (sa, ia) ranks strictly ahead of (sb, ib)
  function automatic logic ranks_before(
    input logic signed [SCORE_W-1:0] sa,
    input logic [ID_W-1:0]           ia,
    input logic signed [SCORE_W-1:0] sb,
    input logic [ID_W-1:0]           ib
  );
    logic r;
    if (sa != sb) begin
      r = (sa > sb);
    end else begin
      r = (ia < ib);
    end
    return r;
  endfunction

endpackage

>>> hdl/osq_cell.sv
// one cell of the sorted chain: holds a single entry and trades with its neighbors
// depends on osq_pkg
module osq_cell (
  input  logic                clk,
  input  logic                rst,
  input  osq_pkg::chain_ctl_t ctl,
  input  osq_pkg::entry_t     left,
  input  logic                left_after,
  input  osq_pkg::entry_t     right,
  output osq_pkg::entry_t     ent,
  output logic                after
);
  import osq_pkg::*;

  entry_t ent_next;

  // key belongs ahead of this cell's entry (or this cell is empty)
  assign after = !ent.valid || ranks_before(ctl.key_score, ctl.key_ident, ent.score, ent.ident);

  always_comb begin
    ent_next = ent;
    case (ctl.cmd)
      CMD_INSERT: begin
        // first cell the key belongs ahead of takes the key, the ones behind move back
        if (after) begin
          if (!left_after) begin
            ent_next.valid = 1'b1;
            ent_next.score = ctl.key_score;
            ent_next.ident = ctl.key_ident;
          end else begin
            ent_next = left;
          end
        end
      end
      CMD_REMOVE: begin
        // target and everything behind it move one place toward the head
        if (ent.valid && !ranks_before(ent.score, ent.ident, ctl.key_score, ctl.key_ident)) begin
          ent_next = right;
        end
      end
      CMD_SHIFT: begin
        ent_next = right;
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

>>> hdl/osq_search.sv
// id lookup across all cells, result registered
// depends on osq_pkg
module osq_search (
  input  logic                                 clk,
  input  logic                                 rst,
  input  osq_pkg::entry_t [osq_pkg::CAPACITY-1:0] cells,
  input  logic [osq_pkg::ID_W-1:0]             key_ident,
  output logic                                 found,
  output logic signed [osq_pkg::SCORE_W-1:0]   found_score
);
  import osq_pkg::*;

  logic                      found_next;
  logic signed [SCORE_W-1:0] score_next;

  // ids are unique, so at most one cell hits and an or-merge picks its score
  always_comb begin
    found_next = 1'b0;
    score_next = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (cells[k].valid && cells[k].ident == key_ident) begin
        found_next = 1'b1;
        score_next = score_next | cells[k].score;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else begin
      found <= found_next;
    end
    found_score <= score_next;
  end

endmodule

>>> hdl/ordered_score_priority_queue.sv
// top level of the ordered score priority queue: sequencer, sorted cell chain, response register
// depends on osq_pkg, osq_cell, osq_search
//
// Holds up to CAPACITY distinct (score, id) entries in a chain of cells kept sorted, highest
// signed Q16.16 score first and ties broken by the smaller id, so cell 0 is always the head.
// Each request word inserts, removes by id, peeks or pops, and yields exactly one response word
// with a status, the head (for pop the head before the pop, otherwise the head after the
// operation; zero with empty_res set when there is none) and the entry count after the
// operation. A request passes in order through acceptance, the registered id lookup across all
// cells, an apply step in which every cell updates at once from its neighbors, and a report
// step that reads the new head into the response register.
// req_ready is high whenever no request is in flight; a response may wait in its register while
// the next request is accepted, and a request stalls only in its last cycle if the previous
// response has not yet been taken. There is no clearing pass after reset: only the state, the
// response valid bit, the lookup hit flag, the cell valid bits and the count are reset.
module ordered_score_priority_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  osq_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output osq_pkg::rsp_word_t rsp
);
  import osq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_REPORT
  } state_t;

  state_t           state;
  req_word_t        req_q;
  status_t          status_q;
  status_t          status_next;
  logic [CNT_W-1:0] occupancy;
  logic [CNT_W-1:0] occupancy_next;
  entry_t           pop_head;
  logic             is_pop;

  // chain wiring
  entry_t [CAPACITY-1:0] cells;
  entry_t [CAPACITY-1:0] left_e;
  entry_t [CAPACITY-1:0] right_e;
  logic   [CAPACITY-1:0] after;
  logic   [CAPACITY-1:0] left_after;
  chain_ctl_t            ctl;

  logic                      found;
  logic signed [SCORE_W-1:0] found_score;

  logic full;
  logic rsp_free;

  assign req_ready = (state == S_IDLE);
  assign full      = (occupancy == CNT_W'(CAPACITY));
  assign rsp_free  = !rsp_valid || rsp_ready;

  osq_search u_search (
    .clk         (clk),
    .rst         (rst),
    .cells       (cells),
    .key_ident   (req_q.item_id),
    .found       (found),
    .found_score (found_score)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_first
      // the head cell has no left neighbor: a key that belongs ahead of it lands here
      assign left_e[k]     = '0;
      assign left_after[k] = 1'b0;
    end else begin : g_mid
      assign left_e[k]     = cells[k-1];
      assign left_after[k] = after[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_e[k] = '0;
    end else begin : g_inner
      assign right_e[k] = cells[k+1];
    end

    osq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .left       (left_e[k]),
      .left_after (left_after[k]),
      .right      (right_e[k]),
      .ent        (cells[k]),
      .after      (after[k])
    );
  end

  // decide the chain command and status during the apply cycle
  always_comb begin
    ctl            = '{cmd: CMD_HOLD, key_score: req_q.item_score, key_ident: req_q.item_id};
    status_next    = ST_DONE;
    occupancy_next = occupancy;
    if (state == S_APPLY) begin
      case (op_t'(req_q.operation))
        OP_INSERT: begin
          if (found) begin
            status_next = ST_DUP;
          end else if (full) begin
            status_next = ST_FULL;
          end else begin
            ctl.cmd        = CMD_INSERT;
            occupancy_next = occupancy + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (!found) begin
            status_next = ST_ABSENT;
          end else begin
            // the removed entry's score from the lookup locates it in the chain
            ctl.cmd        = CMD_REMOVE;
            ctl.key_score  = found_score;
            occupancy_next = occupancy - CNT_W'(1);
          end
        end
        OP_POP: begin
          if (cells[0].valid) begin
            ctl.cmd        = CMD_SHIFT;
            occupancy_next = occupancy - CNT_W'(1);
          end
        end
        default: begin
          ctl.cmd = CMD_HOLD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // the report cycle refills the register itself when the old word leaves
      if (rsp_valid && rsp_ready && state != S_REPORT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          status_q  <= status_next;
          occupancy <= occupancy_next;
          pop_head  <= cells[0];
          is_pop    <= (op_t'(req_q.operation) == OP_POP);
          state     <= S_REPORT;
        end
        S_REPORT: begin
          if (rsp_free) begin
            // pop reports the head taken off; every other operation reports the new head
            if (is_pop) begin
              rsp.head_id    <= pop_head.valid ? pop_head.ident : '0;
              rsp.head_score <= pop_head.valid ? pop_head.score : '0;
              rsp.empty_res  <= !pop_head.valid;
            end else begin
              rsp.head_id    <= cells[0].valid ? cells[0].ident : '0;
              rsp.head_score <= cells[0].valid ? cells[0].score : '0;
              rsp.empty_res  <= !cells[0].valid;
            end
            rsp.status      <= status_q;
            rsp.entry_total <= TOTAL_W'(occupancy);
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end else if (rsp_valid && rsp_ready) begin
            rsp_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/osq_checker.sv
// port-level checks for the ordered score priority queue, bound to the top level
// depends on osq_pkg and ordered_score_priority_queue
module osq_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input osq_pkg::req_word_t req,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input osq_pkg::rsp_word_t rsp
);
  import osq_pkg::*;

  localparam logic [TOTAL_W-1:0] FULL_TOTAL = TOTAL_W'(CAPACITY);

  // a held response word does not change
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // one word in flight: no request taken right after another
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // an empty head reads as zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.empty_res |-> rsp.head_id == '0 && rsp.head_score == '0)
    else $error("empty response carries a head");

  // a rejected insert only happens at capacity, where a head exists
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.entry_total == FULL_TOTAL && !rsp.empty_res)
    else $error("full status with wrong count");

  // no response right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind ordered_score_priority_queue osq_checker u_osq_checker (.*);
